// ===== sv/mbb_pkg.sv =====
`default_nettype none

package mbb_pkg;

  // frame buffer word geometry
  localparam int WORD_BITS   = 32;
  localparam int PITCH_WORDS = 20;
  localparam int SHIFT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W      = 13;

  // port widths fixed by the field list
  localparam int DATA_W      = 32;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 3;

  // register field widths
  localparam int START_X_W   = 10;
  localparam int START_Y_W   = 9;
  localparam int WPR_W       = 5;
  localparam int ROWS_W      = 9;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X       = 3'd0,
    CFG_START_Y       = 3'd1,
    CFG_WORDS_PER_ROW = 3'd2,
    CFG_ROW_COUNT     = 3'd3,
    CFG_CLEAR_MODE    = 3'd4
  } cfg_idx_t;

  // one masked write command
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] mask;
    logic              last;
    logic              done;
  } wr_cmd_t;

  // top left corner word address, modulo the address space
  function automatic logic [ADDR_W-1:0] corner_addr(
    input logic [START_X_W-1:0] sx,
    input logic [START_Y_W-1:0] sy
  );
    logic [ADDR_W-1:0] prod;
    logic [ADDR_W-1:0] col;
    prod = ADDR_W'(sy) * ADDR_W'(PITCH_WORDS);
    col  = ADDR_W'(sx / WORD_BITS);
    return prod + col;
  endfunction

endpackage

`default_nettype wire

// ===== sv/masked_bitmap_blit_top.sv =====
`default_nettype none

// Monochrome bitmap blit: each source word request becomes one masked frame
// buffer write when start_x is word aligned, else two writes to adjacent words
// (first carries the right-shifted pixels, second the remainder). The result
// register sits straight after the shift and mask logic, so aligned requests
// flow at one per cycle while out_stall is low; unaligned ones raise in_stall
// until the follow-up write, held in a second command register, moves into
// the single command port. Writing a defined config index restarts the blit
// at the top left corner; write configuration only while the block is idle.
module masked_bitmap_blit_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [mbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mbb_pkg::CFG_DATA_W-1:0]   cfg_data,
  // source words
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [mbb_pkg::DATA_W-1:0]       in_source_word,
  // write commands
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [mbb_pkg::ADDR_W-1:0]            out_word_address,
  output logic [mbb_pkg::DATA_W-1:0]            out_write_data,
  output logic [mbb_pkg::DATA_W-1:0]            out_write_mask,
  output logic                                  out_item_last,
  output logic                                  out_blit_done
);

  localparam int WB = mbb_pkg::WORD_BITS;
  localparam int SW = mbb_pkg::SHIFT_W;

  // configuration registers
  logic [mbb_pkg::START_X_W-1:0] start_x_r, start_x_nxt;
  logic [mbb_pkg::START_Y_W-1:0] start_y_r, start_y_nxt;
  logic [mbb_pkg::WPR_W-1:0]     wpr_r, wpr_nxt;
  logic [mbb_pkg::ROWS_W-1:0]    rows_r, rows_nxt;
  logic                          clear_r, clear_nxt;

  // position state
  logic [mbb_pkg::WPR_W-1:0]     col_r, col_nxt;
  logic [mbb_pkg::ROWS_W-1:0]    row_r, row_nxt;
  logic [mbb_pkg::ADDR_W-1:0]    row_addr_r, row_addr_nxt;

  // command registers
  logic                          out_valid_r, out_valid_nxt;
  mbb_pkg::wr_cmd_t              out_cmd_r, out_cmd_nxt;
  logic                          sec_valid_r, sec_valid_nxt;
  mbb_pkg::wr_cmd_t              sec_cmd_r, sec_cmd_nxt;

  logic                          in_acc;
  logic                          out_free;
  logic                          cfg_hit;

  logic [WB-1:0]                 ones;
  logic [WB-1:0]                 src;
  logic [SW-1:0]                 shamt;
  logic [SW:0]                   lshamt;
  logic [WB-1:0]                 mask0;
  logic [mbb_pkg::ADDR_W-1:0]    addr;
  logic                          row_end;
  logic                          done;
  mbb_pkg::wr_cmd_t              cmd0, cmd1;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = sec_valid_r || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  // configuration decode
  always_comb begin
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    wpr_nxt     = wpr_r;
    rows_nxt    = rows_r;
    clear_nxt   = clear_r;
    cfg_hit     = 1'b0;
    if (cfg_we) begin
      cfg_hit = 1'b1;
      unique case (cfg_index)
        mbb_pkg::CFG_START_X:       start_x_nxt = cfg_data[mbb_pkg::START_X_W-1:0];
        mbb_pkg::CFG_START_Y:       start_y_nxt = cfg_data[mbb_pkg::START_Y_W-1:0];
        mbb_pkg::CFG_WORDS_PER_ROW: wpr_nxt     = cfg_data[mbb_pkg::WPR_W-1:0];
        mbb_pkg::CFG_ROW_COUNT:     rows_nxt    = cfg_data[mbb_pkg::ROWS_W-1:0];
        mbb_pkg::CFG_CLEAR_MODE:    clear_nxt   = cfg_data[0];
        default:                    cfg_hit     = 1'b0;
      endcase
    end
  end

  // shift and mask for the current request
  assign ones   = '1;
  assign src    = clear_r ? '0 : in_source_word[WB-1:0];
  assign shamt  = SW'(start_x_r % WB);
  assign lshamt = (SW+1)'(WB) - {1'b0, shamt};
  assign mask0  = ones >> shamt;
  assign addr   = row_addr_r + mbb_pkg::ADDR_W'(col_r);

  // end of row and end of bitmap
  assign row_end = ({1'b0, col_r} + 1'b1) >= {1'b0, wpr_r};
  assign done    = row_end && (({1'b0, row_r} + 1'b1) >= {1'b0, rows_r});

  // write commands of one request
  always_comb begin
    cmd0      = '0;
    cmd1      = '0;
    cmd0.addr = addr;
    cmd1.addr = addr + 1'b1;
    cmd1.data = mbb_pkg::DATA_W'(src << lshamt);
    cmd1.mask = mbb_pkg::DATA_W'(~mask0);
    cmd1.last = 1'b1;
    cmd1.done = done;
    if (shamt == '0) begin
      cmd0.data = mbb_pkg::DATA_W'(src);
      cmd0.mask = mbb_pkg::DATA_W'(ones);
      cmd0.last = 1'b1;
      cmd0.done = done;
    end else begin
      cmd0.data = mbb_pkg::DATA_W'(src >> shamt);
      cmd0.mask = mbb_pkg::DATA_W'(mask0);
    end
  end

  // position counters
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    row_addr_nxt = row_addr_r;
    priority if (cfg_hit) begin
      col_nxt      = '0;
      row_nxt      = '0;
      row_addr_nxt = mbb_pkg::corner_addr(start_x_nxt, start_y_nxt);
    end else if (in_acc && done) begin
      col_nxt      = '0;
      row_nxt      = '0;
      row_addr_nxt = mbb_pkg::corner_addr(start_x_r, start_y_r);
    end else if (in_acc && row_end) begin
      col_nxt      = '0;
      row_nxt      = row_r + 1'b1;
      row_addr_nxt = row_addr_r + mbb_pkg::ADDR_W'(mbb_pkg::PITCH_WORDS);
    end else if (in_acc) begin
      col_nxt      = col_r + 1'b1;
    end else begin
      // idle, position holds
      col_nxt      = col_r;
    end
  end

  // command register steering
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cmd_nxt   = out_cmd_r;
    sec_valid_nxt = sec_valid_r;
    sec_cmd_nxt   = sec_cmd_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    priority if (in_acc) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = cmd0;
      sec_valid_nxt = !cmd0.last;
      sec_cmd_nxt   = cmd1;
    end else if (sec_valid_r && out_free) begin
      out_valid_nxt = 1'b1;
      out_cmd_nxt   = sec_cmd_r;
      sec_valid_nxt = 1'b0;
    end else begin
      // pending follow-up write waits
      sec_valid_nxt = sec_valid_r;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r   <= '0;
      start_y_r   <= '0;
      wpr_r       <= mbb_pkg::WPR_W'(1);
      rows_r      <= mbb_pkg::ROWS_W'(1);
      clear_r     <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      row_addr_r  <= '0;
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      wpr_r       <= wpr_nxt;
      rows_r      <= rows_nxt;
      clear_r     <= clear_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      row_addr_r  <= row_addr_nxt;
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_cmd_r <= out_cmd_nxt;
    sec_cmd_r <= sec_cmd_nxt;
  end

  // outputs
  assign out_valid        = out_valid_r;
  assign out_word_address = out_cmd_r.addr;
  assign out_write_data   = out_cmd_r.data;
  assign out_write_mask   = out_cmd_r.mask;
  assign out_item_last    = out_cmd_r.last;
  assign out_blit_done    = out_cmd_r.done;

  // a pending second write always sits behind a first write
  a_sec_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> (out_valid_r && !out_cmd_r.last))
    else $error("second write pending without first write in output");

  // an accepted request shows a write next cycle
  a_acc_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no write");

  // bitmap end only on the last write of a request
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_cmd_r.done) |-> out_cmd_r.last)
    else $error("blit done flagged on a non-final write");

  // the follow-up write targets the next word
  a_sec_addr: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> (sec_cmd_r.addr == out_cmd_r.addr + 1'b1))
    else $error("second write address not adjacent");

endmodule

`default_nettype wire
